// ===== src/hcp_pkg.sv =====
// hcp_pkg: shared widths, constants, codes and controller/datapath types
// for the hexagonal close-packed row generator
// depends on nothing
package hcp_pkg;

   // field and register widths
   localparam int ROW_W      = 5;
   localparam int SHELL_W    = 4;
   localparam int RADIUS_W   = 24;
   localparam int COORD_W    = RADIUS_W + 1;
   localparam int DIVISOR_W  = SHELL_W + 1;

   // grid limits and fixed-point format
   localparam int MAX_SHELLS      = 15;
   localparam int COORD_FRAC_BITS = 16;
   localparam logic [RADIUS_W-1:0] OUTER_RESET = RADIUS_W'(1 << COORD_FRAC_BITS);
   localparam logic [SHELL_W-1:0]  SHELL_RESET = SHELL_W'(1);

   // sqrt(3) in Q30 and the product widths around it
   localparam int SQRT3_W   = 31;
   localparam int Q30_SHIFT = 30;
   localparam logic [SQRT3_W-1:0] SQRT3_Q30 = 31'd1859775393;
   localparam int JR_W      = ROW_W + RADIUS_W;
   localparam int PROD_W    = JR_W + SQRT3_W;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (Q30_SHIFT - 1);

   // column index and circle test widths
   localparam int K_W    = SHELL_W + 2;
   localparam int TEST_W = 2 * K_W + 1;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [ROW_W-1:0]          row_type;
   typedef logic [RADIUS_W-1:0]       radius_type;
   typedef logic [SHELL_W-1:0]        shell_type;

   typedef enum logic {
      REG_SHELL_COUNT,
      REG_OUTER_RADIUS
   } hcp_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_JR,
      ST_MUL_S,
      ST_ROUND,
      ST_HEAD,
      ST_GROUP,
      ST_EMPTY
   } hcp_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_row;
      logic mul_jr;
      logic mul_s;
      logic init_walk;
      logic emit;
      logic advance;
      logic x_zero;
      logic y_zero;
      logic neg_x;
      logic neg_y;
      logic empty;
      logic last;
   } hcp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic row_ok;
      logic row_zero;
      logic row_odd;
      logic test_cur;
      logic test_next;
      logic out_free;
   } hcp_stat_type;

   // shell count clamped to the supported range
   function automatic shell_type shells_used(input shell_type n);
      shells_used = (32'(n) > MAX_SHELLS) ? SHELL_W'(MAX_SHELLS) : n;
   endfunction

endpackage

// ===== src/hcp_if.sv =====
// hcp_req_if / hcp_rsp_if: valid/ready channels for row requests and centers
// depends on hcp_pkg
interface hcp_req_if;
   import hcp_pkg::*;
   logic    valid;
   logic    ready;
   row_type row_index;

   modport source (output valid, output row_index, input ready);
   modport sink   (input valid, input row_index, output ready);
endinterface

interface hcp_rsp_if;
   import hcp_pkg::*;
   logic      valid;
   logic      ready;
   coord_type x_coord;
   coord_type y_coord;
   logic      row_empty;
   logic      last_of_row;

   modport source (output valid, output x_coord, output y_coord, output row_empty,
                   output last_of_row, input ready);
   modport sink   (input valid, input x_coord, input y_coord, input row_empty,
                   input last_of_row, output ready);
endinterface

// ===== src/hcp_div.sv =====
// hcp_div: restoring divider for spacing = outer_radius / (2n+1), one bit a cycle
// depends on hcp_pkg
module hcp_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  hcp_pkg::radius_type             dividend,
   input  logic [hcp_pkg::DIVISOR_W-1:0]   divisor,
   output hcp_pkg::radius_type             quotient,
   output logic                            busy
);
   import hcp_pkg::*;

   localparam int CNT_W = $clog2(RADIUS_W + 1);

   // quotient register doubles as the dividend shift register
   radius_type             q_ff, q_in;
   logic [DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0]   div_ff;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DIVISOR_W:0]     rem_sh;
   logic                   ge;

   always_comb begin
      rem_sh = {rem_ff, q_ff[RADIUS_W-1]};
      ge     = rem_sh >= {1'b0, div_ff};
      q_in   = q_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         q_in   = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(RADIUS_W);
      end else if (busy) begin
         q_in   = {q_ff[RADIUS_W-2:0], ge};
         rem_in = ge ? DIVISOR_W'(rem_sh - {1'b0, div_ff}) : rem_sh[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff   <= '0;
         cnt_ff <= '0;
      end else begin
         q_ff   <= q_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = q_ff;

endmodule

// ===== src/hcp_ctrl.sv =====
// hcp_ctrl: row walk state machine, drives datapath commands
// depends on hcp_pkg
module hcp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  cfg_busy,
   input  hcp_pkg::hcp_stat_type stat,
   output hcp_pkg::hcp_cmd_type  cmd
);
   import hcp_pkg::*;

   hcp_state_type state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic          head_end;
   logic          group_end;

   // row 0 has a one-point head and two-point groups
   assign head_end  = stat.row_zero ? (phase_ff == 2'd0) : (phase_ff == 2'd1);
   assign group_end = stat.row_zero ? (phase_ff == 2'd1) : (phase_ff == 2'd3);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = ST_MUL_JR;
            end
         end
         ST_MUL_JR: begin
            state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            phase_in = '0;
            if (!stat.row_ok) begin
               state_in = ST_EMPTY;
            end else if (stat.row_odd) begin
               state_in = ST_GROUP;
            end else begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (stat.out_free) begin
               if (head_end) begin
                  phase_in = '0;
                  state_in = stat.test_cur ? ST_GROUP : ST_IDLE;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         ST_GROUP: begin
            if (stat.out_free) begin
               if (group_end) begin
                  phase_in = '0;
                  if (!stat.test_next) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         ST_EMPTY: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = !cfg_busy;
            cmd.load_row = req_valid && !cfg_busy;
         end
         ST_MUL_JR: begin
            cmd.mul_jr = 1'b1;
         end
         ST_MUL_S: begin
            cmd.mul_s = 1'b1;
         end
         ST_ROUND: begin
            cmd.init_walk = 1'b1;
         end
         ST_HEAD: begin
            cmd.emit   = stat.out_free;
            cmd.x_zero = 1'b1;
            cmd.neg_y  = phase_ff[0];
            cmd.last   = head_end && !stat.test_cur;
         end
         ST_GROUP: begin
            cmd.emit    = stat.out_free;
            cmd.neg_x   = phase_ff[0];
            cmd.neg_y   = phase_ff[1];
            cmd.last    = group_end && !stat.test_next;
            cmd.advance = stat.out_free && group_end;
         end
         ST_EMPTY: begin
            cmd.emit   = stat.out_free;
            cmd.x_zero = 1'b1;
            cmd.y_zero = 1'b1;
            cmd.empty  = 1'b1;
            cmd.last   = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== src/hcp_datapath.sv =====
// hcp_datapath: row height multiply, column walk, circle test and result register
// depends on hcp_pkg
module hcp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  hcp_pkg::hcp_cmd_type  cmd,
   output hcp_pkg::hcp_stat_type stat,
   input  hcp_pkg::row_type      row_index,
   input  hcp_pkg::shell_type    shells,
   input  hcp_pkg::radius_type   spacing,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hcp_pkg::coord_type    rsp_x_coord,
   output hcp_pkg::coord_type    rsp_y_coord,
   output logic                  rsp_row_empty,
   output logic                  rsp_last_of_row
);
   import hcp_pkg::*;

   row_type            j_ff;
   logic [JR_W-1:0]    jr_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  round_sum;
   radius_type         y_ff;
   radius_type         x_ff;
   logic [K_W-1:0]     k_ff;
   logic [K_W-1:0]     k_next;
   radius_type         two_r;

   logic [TEST_W-1:0]  j_sq;
   logic [TEST_W-1:0]  j_sq3;
   logic [TEST_W-1:0]  lim;
   logic [TEST_W-1:0]  k_sq;
   logic [TEST_W-1:0]  kn_sq;

   logic               rsp_valid_ff, rsp_valid_in;
   coord_type          x_out_ff, y_out_ff;
   logic               empty_ff, last_ff;
   coord_type          x_pos, y_pos, x_sel, y_sel;

   // circle test k^2 + 3j^2 <= 4n^2 on small integers
   assign j_sq   = TEST_W'(j_ff) * TEST_W'(j_ff);
   assign j_sq3  = j_sq + (j_sq << 1);
   assign lim    = (TEST_W'(shells) * TEST_W'(shells)) << 2;
   assign k_next = k_ff + K_W'(2);
   assign k_sq   = TEST_W'(k_ff) * TEST_W'(k_ff);
   assign kn_sq  = TEST_W'(k_next) * TEST_W'(k_next);
   assign two_r  = spacing << 1;

   assign round_sum = prod_ff + ROUND_HALF;

   always_comb begin
      stat.row_zero  = j_ff == '0;
      stat.row_odd   = j_ff[0];
      stat.row_ok    = (j_ff == '0) || (j_sq3 <= lim);
      stat.test_cur  = (k_sq + j_sq3) <= lim;
      stat.test_next = (kn_sq + j_sq3) <= lim;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_row) begin
         j_ff <= row_index;
      end
      if (cmd.mul_jr) begin
         jr_ff <= JR_W'(j_ff) * JR_W'(spacing);
      end
      if (cmd.mul_s) begin
         prod_ff <= PROD_W'(jr_ff) * PROD_W'(SQRT3_Q30);
      end
      if (cmd.init_walk) begin
         y_ff <= round_sum[Q30_SHIFT +: RADIUS_W];
         k_ff <= j_ff[0] ? K_W'(1) : K_W'(2);
         x_ff <= j_ff[0] ? spacing : two_r;
      end else if (cmd.advance) begin
         k_ff <= k_next;
         x_ff <= x_ff + two_r;
      end
   end

   // result register
   always_comb begin
      x_pos = {1'b0, x_ff};
      y_pos = {1'b0, y_ff};
      x_sel = cmd.neg_x ? -x_pos : x_pos;
      y_sel = cmd.neg_y ? -y_pos : y_pos;
      if (cmd.x_zero) begin
         x_sel = '0;
      end
      if (cmd.y_zero) begin
         y_sel = '0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         x_out_ff <= x_sel;
         y_out_ff <= y_sel;
         empty_ff <= cmd.empty;
         last_ff  <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_coord     = x_out_ff;
   assign rsp_y_coord     = y_out_ff;
   assign rsp_row_empty   = empty_ff;
   assign rsp_last_of_row = last_ff;

endmodule

// ===== src/hex_close_pack_row_generator.sv =====
// hex_close_pack_row_generator: top level, csr registers, spacing divider,
// row walk controller and datapath; depends on hcp_pkg, hcp_if, hcp_div,
// hcp_ctrl, hcp_datapath
//
//  channel   direction  handshake                 payload
//  req_if    in         valid/ready               row_index
//  rsp_if    out        valid/ready               x_coord, y_coord, row_empty, last_of_row
//  csr_*     in/out     psel/penable, pready = 1  shell_count @0x0, outer_radius @0x4
//
//  a row is set up by a j*r multiply, a multiply by sqrt(3) and a round,
//  then gives one result per cycle while the result register is free;
//  the setup is bound by the two registered multipliers in the datapath
//  every csr write reruns the spacing divider, one quotient bit a cycle:
//  req_if.ready stays low until the divide is done
//  reset: shell_count 1, outer_radius 1.0, spacing 0, no result pending
//  an rsp stall holds the result register and freezes the walk; the next
//  row is taken as soon as the last result of this one sits in that register
module hex_close_pack_row_generator (
   input  logic                              clock,
   input  logic                              reset,
   hcp_req_if.sink                           req_if,
   hcp_rsp_if.source                         rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hcp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [hcp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [hcp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import hcp_pkg::*;

   shell_type     shell_ff, shell_in;
   radius_type    outer_ff, outer_in;
   logic          start_ff;
   logic          csr_wr;
   hcp_reg_type   csr_reg;

   shell_type     shells;
   radius_type    spacing;
   logic          div_busy;
   logic          cfg_busy;

   hcp_cmd_type   cmd;
   hcp_stat_type  stat;

   // register decode on the word address
   assign csr_reg    = hcp_reg_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      shell_in = shell_ff;
      outer_in = outer_ff;
      if (csr_wr) begin
         case (csr_reg)
            REG_SHELL_COUNT:  shell_in = csr_pwdata[SHELL_W-1:0];
            REG_OUTER_RADIUS: outer_in = csr_pwdata[RADIUS_W-1:0];
            default: begin
               shell_in = shell_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_SHELL_COUNT:  csr_prdata = CSR_DATA_W'(shell_ff);
         REG_OUTER_RADIUS: csr_prdata = CSR_DATA_W'(outer_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // the divider starts the cycle after a write, from the updated registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shell_ff <= SHELL_RESET;
         outer_ff <= OUTER_RESET;
         start_ff <= 1'b0;
      end else begin
         shell_ff <= shell_in;
         outer_ff <= outer_in;
         start_ff <= csr_wr;
      end
   end

   assign shells   = shells_used(shell_ff);
   assign cfg_busy = start_ff || div_busy;

   // spacing = outer / (2n+1)
   hcp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (outer_ff),
      .divisor  ({shells, 1'b1}),
      .quotient (spacing),
      .busy     (div_busy)
   );

   hcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cfg_busy  (cfg_busy),
      .stat      (stat),
      .cmd       (cmd)
   );

   hcp_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .row_index       (req_if.row_index),
      .shells          (shells),
      .spacing         (spacing),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_x_coord     (rsp_if.x_coord),
      .rsp_y_coord     (rsp_if.y_coord),
      .rsp_row_empty   (rsp_if.row_empty),
      .rsp_last_of_row (rsp_if.last_of_row)
   );

endmodule

// ===== src/hcp_checker.sv =====
// hcp_checker: port-level assertions for the row generator, bound to the top level
// depends on hcp_pkg
module hcp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  hcp_pkg::coord_type rsp_x_coord,
   input  hcp_pkg::coord_type rsp_y_coord,
   input  logic               rsp_row_empty,
   input  logic               rsp_last_of_row,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite
);
   import hcp_pkg::*;

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x_coord) &&
      $stable(rsp_y_coord) && $stable(rsp_row_empty) && $stable(rsp_last_of_row))
      else $error("result changed while stalled");

   // an empty row is a single zero result that closes the row
   a_empty_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_empty |-> rsp_last_of_row && rsp_x_coord == '0 &&
      rsp_y_coord == '0)
      else $error("empty row result malformed");

   // rows are worked one at a time, setup follows each transfer
   a_one_row: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during row setup");

   // a csr write holds off requests while spacing is recomputed
   a_cfg_block: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=> !req_ready)
      else $error("request taken while spacing recomputes");

   // nothing pending out of reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind hex_close_pack_row_generator hcp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_x_coord     (rsp_if.x_coord),
   .rsp_y_coord     (rsp_if.y_coord),
   .rsp_row_empty   (rsp_if.row_empty),
   .rsp_last_of_row (rsp_if.last_of_row),
   .csr_psel        (csr_psel),
   .csr_penable     (csr_penable),
   .csr_pwrite      (csr_pwrite)
);

// ===== tb/tb_hex_close_pack_row_generator.sv =====
// tb_hex_close_pack_row_generator: self-checking bench for the hex close-pack row
// generator, with its own row predictor, random flow control and csr phases
// depends on hcp_pkg, hcp_if and the hex_close_pack_row_generator rtl
module tb_hex_close_pack_row_generator;
   import hcp_pkg::*;

   // one expected circle center, same fields as a result transfer
   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      empty;
      logic      last;
   } center_type;

   logic clock;
   logic reset;

   hcp_req_if req_if();
   hcp_rsp_if rsp_if();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   hex_close_pack_row_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor copy of the registers and the derived spacing
   shell_type  grid_shells  = SHELL_RESET;
   radius_type grid_outer   = OUTER_RESET;
   radius_type grid_spacing = '0;       // zero until the first csr write

   // centers still owed by the block, oldest first
   center_type pending_centers[$];

   // flow control knobs, percent of cycles spent idle
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold     = 0;                 // cycles left in a forced receiver stall

   int error_count     = 0;
   int rows_sent       = 0;
   int centers_checked = 0;
   int csr_writes      = 0;
   int empty_rows_seen = 0;

   // 100 MHz-style free running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous fixed limit, far above the slowest legal run
   initial begin
      #20_000_000;
      $display("timeout: %0d centers still pending", pending_centers.size());
      $display("Simulation FAILED");
      $finish;
   end

   // one line per mismatch
   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("mismatch on %s: got %0d, expected %0d (center %0d)",
               what, got, want, centers_checked);
   endtask

   function automatic void add_center(input coord_type x, input coord_type y,
                                      input logic empty);
      center_type c;
      c.x     = x;
      c.y     = y;
      c.empty = empty;
      c.last  = 1'b0;
      pending_centers.insert(pending_centers.size(), c);
   endfunction

   // works out every center a row request produces, in output order
   task automatic predict_row_centers(input row_type row);
      int unsigned       n;
      int unsigned       j;
      int unsigned       circle_lim;
      int unsigned       k;
      int                first;
      longint unsigned   r;
      longint unsigned   y_scaled;
      coord_type         x;
      coord_type         y;
      n          = grid_shells;
      j          = row;
      r          = grid_spacing;
      circle_lim = 4 * n * n;
      first      = pending_centers.size();
      if (j == 0) begin
         // x axis: origin, then the mirrored pairs at even columns
         add_center('0, '0, 1'b0);
         for (int unsigned i = 1; i <= n; i++) begin
            x = coord_type'(2 * i * r);
            add_center(x, '0, 1'b0);
            add_center(-x, '0, 1'b0);
         end
      end else if (3 * j * j <= circle_lim) begin
         // row height j*r*sqrt(3), rounded half up out of q30
         y_scaled = (longint'(j) * r * longint'(SQRT3_Q30) + (64'd1 << (Q30_SHIFT - 1)))
                    >> Q30_SHIFT;
         y = coord_type'(y_scaled);
         if (j[0] == 1'b0) begin
            add_center('0, y, 1'b0);
            add_center('0, -y, 1'b0);
         end
         for (int unsigned i = 1; i <= n; i++) begin
            k = j[0] ? 2 * i - 1 : 2 * i;
            if (k * k + 3 * j * j > circle_lim) break;
            x = coord_type'(k * r);
            add_center(x, y, 1'b0);
            add_center(-x, y, 1'b0);
            add_center(x, -y, 1'b0);
            add_center(-x, -y, 1'b0);
         end
      end
      // nothing inside the aperture: a single empty-marked center
      if (pending_centers.size() == first) begin
         add_center('0, '0, 1'b1);
      end
      pending_centers[$].last = 1'b1;
   endtask

   // receiver: random ready, or a forced stall counted down cycle by cycle
   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rx_hold--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // result checker, one transfer per edge at most
   always @(posedge clock) begin : check_center
      center_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_centers.size() == 0) begin
            report_mismatch("unexpected result", rsp_if.x_coord, 0);
         end else begin
            want = pending_centers.pop_front();
            if (rsp_if.x_coord !== want.x)
               report_mismatch("x_coord", rsp_if.x_coord, want.x);
            if (rsp_if.y_coord !== want.y)
               report_mismatch("y_coord", rsp_if.y_coord, want.y);
            if (rsp_if.row_empty !== want.empty)
               report_mismatch("row_empty", rsp_if.row_empty, want.empty);
            if (rsp_if.last_of_row !== want.last)
               report_mismatch("last_of_row", rsp_if.last_of_row, want.last);
            if (want.empty) empty_rows_seen++;
            centers_checked++;
         end
      end
   end

   // offers one row request and returns at the edge where it transfers;
   // valid is left high so a following call can present the next row at once
   task automatic send_row(input row_type row);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_if.valid     <= 1'b1;
      req_if.row_index <= row;
      predict_row_centers(row);
      rows_sent++;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // drop valid and let every owed center come out, plus a short margin
   task automatic drain_rows();
      req_if.valid <= 1'b0;
      while (pending_centers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle; pready is tied high
   task automatic write_register(input hcp_reg_type which, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(which));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // every write reruns the spacing divide in the block
      if (which == REG_SHELL_COUNT) grid_shells = value[SHELL_W-1:0];
      else                          grid_outer  = value[RADIUS_W-1:0];
      grid_spacing = radius_type'(grid_outer / (2 * grid_shells + 1));
      csr_writes++;
   endtask

   task automatic set_grid(input int unsigned shells, input int unsigned outer);
      drain_rows();
      write_register(REG_SHELL_COUNT, CSR_DATA_W'(shells));
      write_register(REG_OUTER_RADIUS, CSR_DATA_W'(outer));
   endtask

   // reset state: spacing still zero, so every coordinate comes out zero
   task automatic test_unconfigured_spacing();
      send_row(5'd0);
      send_row(5'd1);
      send_row(5'd2);   // past the row limit of one shell
      send_row(5'd31);
      drain_rows();
   endtask

   // largest grid and radius, then the smallest nonzero radius
   task automatic test_field_extremes();
      set_grid(MAX_SHELLS, 24'hFFFFFF);
      send_row(5'd0);
      send_row(5'd1);
      send_row(5'd16);
      send_row(5'd17);  // last row inside the aperture
      send_row(5'd18);  // first row outside
      send_row(5'd31);
      set_grid(1, 1);   // spacing rounds down to zero
      send_row(5'd0);
      send_row(5'd1);
      drain_rows();
   endtask

   // zero shell count uses divisor one; zero radius gives all-zero centers
   task automatic test_degenerate_config();
      set_grid(0, 65536);
      send_row(5'd0);
      send_row(5'd1);
      send_row(5'd5);
      set_grid(7, 0);
      send_row(5'd0);
      send_row(5'd3);
      drain_rows();
   endtask

   // random rows over a few random grids; most rows land inside the aperture
   task automatic test_random_rows(input int count, input int tx_pct, input int rx_pct);
      int      row_limit;
      int      shells;
      int      outer;
      row_type row;
      drain_rows();
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      row_limit   = 0;
      for (int c = 0; c < count; c++) begin
         if (c % 40 == 0) begin
            case ($urandom_range(5))
               0:       shells = MAX_SHELLS;
               1:       shells = 1;
               default: shells = $urandom_range(MAX_SHELLS, 1);
            endcase
            case ($urandom_range(5))
               0:       outer = 24'hFFFFFF;
               1:       outer = $urandom_range(255, 1);
               default: outer = $urandom_range(24'hFFFFFF, 1);
            endcase
            set_grid(shells, outer);
            // highest row with 3j^2 <= 4n^2
            row_limit = 0;
            while (3 * (row_limit + 1) * (row_limit + 1) <= 4 * shells * shells)
               row_limit++;
         end
         if ($urandom_range(9) < 8) row = row_type'($urandom_range(row_limit));
         else                       row = row_type'($urandom_range(31));
         send_row(row);
      end
      drain_rows();
   endtask

   // receiver stalls for a long stretch while rows keep coming, so the
   // result register fills and the block has to hold off its input
   task automatic test_result_backpressure();
      set_grid(MAX_SHELLS, $urandom_range(24'hFFFFFF, 24'h800000));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold     = 500;
      for (int c = 0; c < 12; c++) begin
         send_row(row_type'($urandom_range(3)));
      end
      drain_rows();
   endtask

   initial begin
      reset           = 1'b1;
      req_if.valid     <= 1'b0;
      req_if.row_index <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles 31%, receiver 64% for the directed part and first random pass
      tx_idle_pct = 31;
      rx_idle_pct = 64;
      test_unconfigured_spacing();
      test_field_extremes();
      test_degenerate_config();
      test_random_rows(160, 31, 64);
      test_random_rows(160, 64, 31);
      test_random_rows(160, 0, 0);
      test_result_backpressure();

      // let anything stray come out before judging
      repeat (80) @(posedge clock);
      $display("covered %0d row requests and %0d centers over %0d register writes",
               rows_sent, centers_checked, csr_writes);
      $display("%0d rows came back empty; one long receiver stall filled the block",
               empty_rows_seen);
      if (error_count == 0 && pending_centers.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
